// File: sv/assert_macros.svh
// assertion helpers used by the filter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/tdf_pkg.sv
`default_nettype none
package tdf_pkg;

   localparam int TABLE_SLOTS    = 512;
   localparam int SLOT_BITS      = $clog2(TABLE_SLOTS);
   localparam int KEY_BITS       = 64;
   localparam int STAMP_BITS     = 32;
   localparam int COUNT_BITS     = 10;
   localparam int TTL_BITS       = 16;
   localparam int ADDR_BITS      = 3;
   localparam int DATA_BITS      = 32;

   localparam logic [TTL_BITS-1:0]   TTL_FALLBACK   = TTL_BITS'(5);
   localparam logic [COUNT_BITS-1:0] LIMIT_FALLBACK = COUNT_BITS'(512);

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic {
      REG_TTL   = 1'b0,
      REG_LIMIT = 1'b1
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_CLEAN,
      ST_ROOM,
      ST_INSERT
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [TTL_BITS-1:0]   ttl;
      logic [COUNT_BITS-1:0] limit;
   } cfg_type;

endpackage
`default_nettype wire

// File: sv/ttl_duplicate_filter_core.sv
`default_nettype none
// tick, clear and unused words: result strobe in the cycle after start, one word per cycle
// check word: a lookup pass over every slot and a decide step, then an insert pass for a new key;
// each purge or eviction pass adds a clean pass over every slot and a room step
// the lookup ring turns once per pass, one slot per cycle past the head unit
// result strobe is high for one cycle and cannot be stalled
// synchronous active-high reset empties the table, zeroes time and restores ttl 5, limit 512
`include "assert_macros.svh"
module ttl_duplicate_filter_core import tdf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_op,
   input  wire logic [63:0]           req_key_hash,
   // result channel
   output logic                       rsp_strobe,
   output logic                       rsp_drop,
   output logic      [COUNT_BITS-1:0] rsp_entry_count,
   output logic      [COUNT_BITS-1:0] rsp_removed_count,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_BITS-1:0]  paddr,
   input  wire logic [DATA_BITS-1:0]  pwdata,
   output logic      [DATA_BITS-1:0]  prdata,
   output logic                       pready
);

   cfg_type cfg;

   tdf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ring of cells: slot at the head is cell 0, the head unit feeds the tail
   entry_type ring [TABLE_SLOTS];
   entry_type tail_in;
   entry_type head;
   logic      shift_en;
   logic      clear_all;

   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      entry_type nxt;
      if (i == TABLE_SLOTS - 1) begin : g_tail
         assign nxt = tail_in;
      end else begin : g_mid
         assign nxt = ring[i+1];
      end
      tdf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .clear_all  (clear_all),
         .entry_next (nxt),
         .entry      (ring[i])
      );
   end

   assign head = ring[0];

   state_type             state_ff, state_in;
   logic [SLOT_BITS-1:0]  step_ff, step_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [STAMP_BITS-1:0] time_ff, time_in;
   logic [COUNT_BITS-1:0] live_ff, live_in;
   logic [COUNT_BITS-1:0] others_ff, others_in;
   logic [COUNT_BITS-1:0] removed_ff, removed_in;
   logic                  drop_ff, drop_in;
   logic                  found_ff, found_in;
   logic [SLOT_BITS-1:0]  hit_ff, hit_in;
   logic                  purge_ff, purge_in;
   logic                  victim_valid_ff, victim_valid_in;
   logic [SLOT_BITS-1:0]  victim_ff, victim_in;
   logic                  best_found_ff, best_found_in;
   logic [SLOT_BITS-1:0]  best_ff, best_in;
   logic [STAMP_BITS-1:0] best_age_ff, best_age_in;
   logic                  ins_done_ff, ins_done_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_drop_ff, rsp_drop_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [COUNT_BITS-1:0] rsp_removed_ff, rsp_removed_in;

   logic [STAMP_BITS-1:0] age;
   logic                  expired;
   logic                  last;
   logic                  eligible;
   logic                  kill;
   logic                  finish;

   // modular age of the slot at the head
   assign age     = time_ff - head.stamp;
   assign expired = age >= STAMP_BITS'(cfg.ttl);
   assign last    = step_ff == SLOT_BITS'(TABLE_SLOTS - 1);
   assign busy    = state_ff != ST_IDLE;

   // clean pass: the refreshed hit slot is never removed
   assign eligible = head.valid && !(found_ff && step_ff == hit_ff);
   assign kill     = eligible && ((purge_ff && expired) ||
                                  (victim_valid_ff && step_ff == victim_ff));

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      key_in          = key_ff;
      time_in         = time_ff;
      live_in         = live_ff;
      others_in       = others_ff;
      removed_in      = removed_ff;
      drop_in         = drop_ff;
      found_in        = found_ff;
      hit_in          = hit_ff;
      purge_in        = purge_ff;
      victim_valid_in = victim_valid_ff;
      victim_in       = victim_ff;
      best_found_in   = best_found_ff;
      best_in         = best_ff;
      best_age_in     = best_age_ff;
      ins_done_in     = ins_done_ff;
      rsp_strobe_in   = 1'b0;
      rsp_drop_in     = rsp_drop_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_removed_in  = rsp_removed_ff;
      tail_in         = head;
      shift_en        = 1'b0;
      clear_all       = 1'b0;
      finish          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op_type'(req_op))
                  OP_CHECK: begin
                     key_in        = req_key_hash[KEY_BITS-1:0];
                     drop_in       = 1'b0;
                     found_in      = 1'b0;
                     removed_in    = '0;
                     step_in       = '0;
                     ins_done_in   = 1'b0;
                     purge_in      = 1'b0;
                     victim_valid_in = 1'b0;
                     best_found_in = 1'b0;
                     state_in      = ST_SEARCH;
                  end
                  OP_TICK: begin
                     time_in        = time_ff + 1'b1;
                     rsp_strobe_in  = 1'b1;
                     rsp_drop_in    = 1'b0;
                     rsp_count_in   = live_ff;
                     rsp_removed_in = '0;
                  end
                  OP_CLEAR: begin
                     clear_all      = 1'b1;
                     live_in        = '0;
                     rsp_strobe_in  = 1'b1;
                     rsp_drop_in    = 1'b0;
                     rsp_count_in   = '0;
                     rsp_removed_in = '0;
                  end
                  default: begin
                     rsp_strobe_in  = 1'b1;
                     rsp_drop_in    = 1'b0;
                     rsp_count_in   = live_ff;
                     rsp_removed_in = '0;
                  end
               endcase
            end
         end

         // lookup pass: a live match drops, an expired match is restamped on the fly
         ST_SEARCH: begin
            shift_en = 1'b1;
            step_in  = last ? '0 : step_ff + 1'b1;
            if (head.valid && head.key == key_ff) begin
               found_in = 1'b1;
               hit_in   = step_ff;
               if (!expired) begin
                  drop_in = 1'b1;
               end else begin
                  tail_in.stamp = time_ff;
               end
            end
            if (last) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            others_in = found_ff ? live_ff - 1'b1 : live_ff;
            if (drop_ff) begin
               finish = 1'b1;
            end else if (others_in >= cfg.limit) begin
               purge_in        = 1'b1;
               victim_valid_in = 1'b0;
               best_found_in   = 1'b0;
               state_in        = ST_CLEAN;
            end else if (found_ff) begin
               finish = 1'b1;
            end else begin
               state_in = ST_INSERT;
            end
         end

         // purge or evict pass, searching the next oldest survivor meanwhile
         ST_CLEAN: begin
            shift_en = 1'b1;
            step_in  = last ? '0 : step_ff + 1'b1;
            tail_in.valid = head.valid && !kill;
            if (kill) begin
               removed_in = removed_ff + 1'b1;
               others_in  = others_ff - 1'b1;
               live_in    = live_ff - 1'b1;
            end else if (eligible && (!best_found_ff || age > best_age_ff)) begin
               best_found_in = 1'b1;
               best_in       = step_ff;
               best_age_in   = age;
            end
            if (last) begin
               state_in = ST_ROOM;
            end
         end

         ST_ROOM: begin
            if (others_ff >= cfg.limit && others_ff != '0 && best_found_ff) begin
               victim_in       = best_ff;
               victim_valid_in = 1'b1;
               purge_in        = 1'b0;
               best_found_in   = 1'b0;
               state_in        = ST_CLEAN;
            end else if (found_ff) begin
               finish = 1'b1;
            end else begin
               state_in = ST_INSERT;
            end
         end

         // new key goes into the lowest free slot
         ST_INSERT: begin
            shift_en = 1'b1;
            step_in  = last ? '0 : step_ff + 1'b1;
            if (!head.valid && !ins_done_ff) begin
               tail_in     = '{valid: 1'b1, key: key_ff, stamp: time_ff};
               ins_done_in = 1'b1;
               live_in     = live_ff + 1'b1;
            end
            if (last) begin
               finish = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in       = ST_IDLE;
         rsp_strobe_in  = 1'b1;
         rsp_drop_in    = drop_ff;
         rsp_count_in   = live_in;
         rsp_removed_in = removed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         time_ff       <= '0;
         live_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         time_ff       <= time_in;
         live_ff       <= live_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // per-word working registers, always loaded before use
   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      others_ff       <= others_in;
      removed_ff      <= removed_in;
      drop_ff         <= drop_in;
      found_ff        <= found_in;
      hit_ff          <= hit_in;
      purge_ff        <= purge_in;
      victim_valid_ff <= victim_valid_in;
      victim_ff       <= victim_in;
      best_found_ff   <= best_found_in;
      best_ff         <= best_in;
      best_age_ff     <= best_age_in;
      ins_done_ff     <= ins_done_in;
      rsp_drop_ff     <= rsp_drop_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_removed_ff  <= rsp_removed_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_drop          = rsp_drop_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_removed_count = rsp_removed_ff;

   `ASSERT_IMPLIES(a_live_bound, clock, reset, 1'b1, live_ff <= COUNT_BITS'(TABLE_SLOTS))
   `ASSERT_NEXT(a_check_busy, clock, reset, start && !busy && req_op == OP_CHECK, busy)
   `ASSERT_IMPLIES(a_idle_step, clock, reset, !busy, step_ff == '0)
   `ASSERT_IMPLIES(a_drop_keeps, clock, reset, rsp_strobe && rsp_drop, rsp_removed_count == '0)

endmodule
`default_nettype wire

// File: sv/tdf_cell.sv
`default_nettype none
module tdf_cell import tdf_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      shift_en,
   input  wire logic      clear_all,
   input  wire entry_type entry_next,
   output entry_type      entry
);

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   // valid bit: cleared by reset or a table clear
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= entry_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         key_ff   <= entry_next.key;
         stamp_ff <= entry_next.stamp;
      end
   end

   assign entry = '{valid: valid_ff, key: key_ff, stamp: stamp_ff};

endmodule
`default_nettype wire

// File: sv/tdf_csr.sv
`default_nettype none
module tdf_csr import tdf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output logic      [DATA_BITS-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic [TTL_BITS-1:0]   ttl_ff;
   logic [COUNT_BITS-1:0] limit_ff;
   logic [COUNT_BITS-1:0] limit_raw;
   reg_type               reg_sel;
   logic                  wr_en;

   assign reg_sel = reg_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff   <= TTL_FALLBACK;
         limit_ff <= LIMIT_FALLBACK;
      end else if (wr_en) begin
         case (reg_sel)
            REG_TTL:   ttl_ff   <= pwdata[TTL_BITS-1:0];
            REG_LIMIT: limit_ff <= pwdata[COUNT_BITS-1:0];
            default:   ttl_ff   <= ttl_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TTL:   prdata = DATA_BITS'(ttl_ff);
         REG_LIMIT: prdata = DATA_BITS'(limit_ff);
         default:   prdata = '0;
      endcase
   end

   // zero falls back to defaults, limit saturates at the table size
   assign limit_raw = (limit_ff == '0) ? LIMIT_FALLBACK : limit_ff;
   assign cfg.ttl   = (ttl_ff == '0) ? TTL_FALLBACK : ttl_ff;
   assign cfg.limit = (limit_raw > COUNT_BITS'(TABLE_SLOTS)) ?
                      COUNT_BITS'(TABLE_SLOTS) : limit_raw;

endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
   import tdf_pkg::*;

   localparam int LIMIT_CYCLES = 5_000_000;
   localparam int PHASE_WORDS  = 88;

   typedef struct packed {
      bit                  drop;
      bit [COUNT_BITS-1:0] entries;
      bit [COUNT_BITS-1:0] removed;
   } verdict_type;

   typedef struct {
      op_type      op;
      bit [63:0]   key;
      bit          typed;
      verdict_type res;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [1:0]            req_op = OP_NONE;
   logic [63:0]           req_key_hash = '0;
   logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_BITS-1:0]  paddr = '0;
   logic [DATA_BITS-1:0]  pwdata = '0;
   wire                   busy, rsp_strobe, rsp_drop, pready;
   wire [COUNT_BITS-1:0]  rsp_entry_count, rsp_removed_count;
   wire [DATA_BITS-1:0]   prdata;

   ttl_duplicate_filter_core dut (.*);

   always #5 clock = ~clock;

   // filter model state, mirrors the table slot by slot
   bit                  tab_valid [TABLE_SLOTS];
   bit [63:0]           tab_key   [TABLE_SLOTS];
   bit [31:0]           tab_stamp [TABLE_SLOTS];
   bit [31:0]           now_ticks;
   int unsigned         live_entries;
   bit [15:0]           ttl_reg = 16'd5;
   bit [9:0]            limit_reg = 10'd512;

   verdict_type         pending_words [$];
   int                  failures;
   int                  cycles;
   bit                  idle_on;
   bit [63:0]           key_pool [16];

   function automatic bit [31:0] age_of(int s);
      return now_ticks - tab_stamp[s];
   endfunction

   function automatic int unsigned live_ttl();
      return (ttl_reg == 0) ? 5 : ttl_reg;
   endfunction

   // purge expired, then evict oldest (lowest slot on a tie), sparing slot keep
   function automatic int unsigned make_room(int keep, int unsigned others);
      int unsigned lim, removed, best;
      bit [31:0] best_age;
      lim = (limit_reg == 0) ? 512 : limit_reg;
      if (lim > TABLE_SLOTS) lim = TABLE_SLOTS;
      removed = 0;
      if (others + 1 <= lim) return 0;
      for (int s = 0; s < TABLE_SLOTS; s++)
         if (s != keep && tab_valid[s] && age_of(s) >= live_ttl()) begin
            tab_valid[s] = 0;
            others--;
            removed++;
         end
      while (others + 1 > lim && others > 0) begin
         best = TABLE_SLOTS;
         best_age = 0;
         for (int s = 0; s < TABLE_SLOTS; s++)
            if (s != keep && tab_valid[s] && (best == TABLE_SLOTS || age_of(s) > best_age)) begin
               best = s;
               best_age = age_of(s);
            end
         if (best == TABLE_SLOTS) break;
         tab_valid[best] = 0;
         others--;
         removed++;
      end
      return removed;
   endfunction

   function automatic verdict_type filter_word(op_type op, bit [63:0] key);
      verdict_type r;
      int hit;
      r = '0;
      hit = TABLE_SLOTS;
      case (op)
         OP_CHECK: begin
            for (int s = 0; s < TABLE_SLOTS; s++)
               if (hit == TABLE_SLOTS && tab_valid[s] && tab_key[s] == key) hit = s;
            if (hit < TABLE_SLOTS && age_of(hit) < live_ttl()) begin
               r.drop = 1;
            end else if (hit < TABLE_SLOTS) begin
               // expired entry is restamped in place, not counted as removed
               tab_stamp[hit] = now_ticks;
               r.removed = COUNT_BITS'(make_room(hit, live_entries - 1));
               live_entries -= r.removed;
            end else begin
               r.removed = COUNT_BITS'(make_room(TABLE_SLOTS, live_entries));
               live_entries -= r.removed;
               for (int s = 0; s < TABLE_SLOTS; s++)
                  if (hit == TABLE_SLOTS && !tab_valid[s]) begin
                     hit = s;
                     tab_valid[s] = 1;
                     tab_key[s] = key;
                     tab_stamp[s] = now_ticks;
                     live_entries++;
                  end
            end
         end
         OP_TICK: now_ticks++;
         OP_CLEAR: begin
            foreach (tab_valid[s]) tab_valid[s] = 0;
            live_entries = 0;
         end
         default: ;
      endcase
      r.entries = COUNT_BITS'(live_entries);
      return r;
   endfunction

   task automatic report(string what, verdict_type got, verdict_type want);
      failures++;
      $display("mismatch %s: got drop %0d count %0d removed %0d, want %0d %0d %0d", what,
               got.drop, got.entries, got.removed, want.drop, want.entries, want.removed);
   endtask

   // result words cannot be held off, so each strobe is checked at its edge
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_drop, rsp_entry_count, rsp_removed_count};
         if (pending_words.size() == 0) begin
            report("unexpected word", got, '0);
         end else begin
            want = pending_words.pop_front();
            if (got != want) report("result word", got, want);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // entered at or after a negedge-aligned point; start only drops for an idle gap
   task automatic issue(op_type op, bit [63:0] key, bit typed = 0, verdict_type res = '0);
      verdict_type p;
      @(negedge clock);
      if (idle_on && $urandom_range(99) < 37) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_key_hash <= key;
      do @(posedge clock); while (busy);
      p = filter_word(op, key);
      pending_words.push_back(typed ? res : p);
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write with a setup phase and an access phase, block idle
   task automatic write_reg(reg_type r, bit [31:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_BITS'(4 * int'(r));
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (r == REG_TTL) ttl_reg = value[15:0];
      else limit_reg = value[9:0];
   endtask

   function automatic bit [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   row_type directed [$];
   int   ttl_plan   [6] = '{5, 0, 1, 65535, 2, 3};
   int   limit_plan [6] = '{512, 0, 1, 3, 8, 1023};
   int   pick;
   bit [63:0] k;

   initial begin
      // directed words after reset: ttl 5, limit 512
      directed = '{
         '{OP_CHECK, 64'h0,                  1, '{1'b0, 10'd1, 10'd0}},
         '{OP_CHECK, 64'h0,                  1, '{1'b1, 10'd1, 10'd0}},
         '{OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 1, '{1'b0, 10'd2, 10'd0}},
         '{OP_NONE,  64'hFFFF_FFFF_FFFF_FFFF, 1, '{1'b0, 10'd2, 10'd0}},
         '{OP_TICK,  64'h0,                  1, '{1'b0, 10'd2, 10'd0}},
         '{OP_TICK,  64'h0,                  0, '0},
         '{OP_TICK,  64'h0,                  0, '0},
         '{OP_CHECK, 64'h0,                  1, '{1'b1, 10'd2, 10'd0}},
         '{OP_TICK,  64'h0,                  0, '0},
         '{OP_TICK,  64'h0,                  0, '0},
         // age now equals ttl: expired entries are restamped
         '{OP_CHECK, 64'h0,                  1, '{1'b0, 10'd2, 10'd0}},
         '{OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 1, '{1'b0, 10'd2, 10'd0}},
         '{OP_CHECK, 64'h8000_0000_0000_0001, 0, '0},
         '{OP_CLEAR, 64'h0,                  1, '{1'b0, 10'd0, 10'd0}},
         '{OP_CHECK, 64'h5555_AAAA_5555_AAAA, 1, '{1'b0, 10'd1, 10'd0}}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1;
      foreach (directed[i]) issue(directed[i].op, directed[i].key, directed[i].typed,
                                  directed[i].res);

      // limit of one with short ttl: every new key removes the older one, by eviction or by purge
      settle();
      write_reg(REG_TTL, 2);
      write_reg(REG_LIMIT, 1);
      issue(OP_CHECK, 64'h1);
      issue(OP_CHECK, 64'h2);
      issue(OP_TICK, 64'h0);
      issue(OP_TICK, 64'h0);
      issue(OP_CHECK, 64'h3);
      issue(OP_CHECK, 64'h2);

      foreach (ttl_plan[ph]) begin
         // empty the table before shrinking the limit, so evictions stay few
         issue(OP_CLEAR, rand_key());
         settle();
         write_reg(REG_TTL, ttl_plan[ph] | ($urandom_range(1) << 16));
         write_reg(REG_LIMIT, limit_plan[ph]);
         foreach (key_pool[i]) key_pool[i] = rand_key();
         for (int n = 0; n < PHASE_WORDS; n++) begin
            idle_on = !(ph == 2 && n > 20);
            pick = $urandom_range(99);
            k = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(15)];
            if (pick < 55) issue(OP_CHECK, k);
            else if (pick < 90) issue(OP_TICK, rand_key());
            else if (pick < 96) issue(OP_CLEAR, rand_key());
            else issue(OP_NONE, rand_key());
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
